/* hw/rtl/adi_rhs_column_stencil_assert.svh */
// Assertion macros shared by the column stencil RTL.
// Both sample on aclk and are disabled while aresetn is low.
`ifndef ADI_RHS_COLUMN_STENCIL_ASSERT_SVH
`define ADI_RHS_COLUMN_STENCIL_ASSERT_SVH

// Same-cycle implication.
`define ADI_RCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ADI_RCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/adi_rcs_pkg.sv */
package adi_rcs_pkg;

    // Q16.16 datapath
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    // three truncated products plus the source term
    localparam int SUM_WIDTH   = PROD_WIDTH - FRAC_BITS + 2;
    localparam int INDEX_WIDTH = 8;
    localparam int GRID_WIDTH  = 9;

    // configuration register indexes
    localparam int CFG_ADDR_WIDTH = 2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_GRID_SIZE    = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_COEFF_MODE   = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SCALAR_COEFF = 2'd2;

    localparam logic [GRID_WIDTH-1:0] GRID_SIZE_RESET = 9'd256;

    // operands of one stencil result: a*ul + c*ur + d*u + f
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] a;
        logic signed [VALUE_WIDTH-1:0] ul;
        logic signed [VALUE_WIDTH-1:0] c;
        logic signed [VALUE_WIDTH-1:0] ur;
        logic signed [VALUE_WIDTH-1:0] d;
        logic signed [VALUE_WIDTH-1:0] u;
        logic signed [VALUE_WIDTH-1:0] f;
    } ops_t;

    // register enables of the arithmetic stages
    typedef struct packed {
        logic prod;
        logic sum;
    } stage_en_t;

    // per-request result bookkeeping
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] row;
        logic [INDEX_WIDTH-1:0] col_prev;
        logic [INDEX_WIDTH-1:0] col_cur;
        logic                   has_res;
        logic                   two;
        logic                   end_grid;
    } meta_t;

endpackage

/* hw/rtl/adi_rcs_stencil_unit.sv */
module adi_rcs_stencil_unit (
    input  logic                                      aclk,
    input  adi_rcs_pkg::stage_en_t                    en,
    input  adi_rcs_pkg::ops_t                         ops,
    output logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0] rhs
);

    localparam int VW = adi_rcs_pkg::VALUE_WIDTH;
    localparam int FB = adi_rcs_pkg::FRAC_BITS;
    localparam int PW = adi_rcs_pkg::PROD_WIDTH;
    localparam int SW = adi_rcs_pkg::SUM_WIDTH;

    logic signed [PW-1:0] p0_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [VW-1:0] f_reg;
    logic signed [VW-1:0] rhs_reg;
    logic signed [VW-1:0] rhs_next;
    logic signed [SW-1:0] sum;
    logic                 ovf;

    // multiply stage: exact products
    always_ff @(posedge aclk) begin
        if (en.prod) begin
            p0_reg <= PW'(ops.a) * PW'(ops.ul);
            p1_reg <= PW'(ops.c) * PW'(ops.ur);
            p2_reg <= PW'(ops.d) * PW'(ops.u);
            f_reg  <= ops.f;
        end
    end

    // floor each product, add, saturate
    always_comb begin
        sum = SW'($signed(p0_reg[PW-1:FB])) + SW'($signed(p1_reg[PW-1:FB]))
            + SW'($signed(p2_reg[PW-1:FB])) + SW'(f_reg);
        ovf = !(&sum[SW-1:VW-1]) && (|sum[SW-1:VW-1]);
        if (ovf) begin
            rhs_next = sum[SW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            rhs_next = sum[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            rhs_reg <= rhs_next;
        end
    end

    assign rhs = rhs_reg;

endmodule

/* hw/rtl/adi_rhs_column_stencil.sv */
// Three-point column stencil for the explicit half step of an ADI solver.
// Input channel s_*: one grid point per request, column-major, row fastest.
// Output channel m_*: rhs results, each tagged with its row and column.
// A point in column 0 gives no result; a point in column j >= 1 gives the
// result for column j-1; a point in the last column gives a second result,
// for itself, right after the first (m_last_in_step marks the final one).
// Config channel cfg_*: always ready; write only while the block is idle.
// Index 0 grid_size (also restarts the grid), 1 coeff_mode, 2 scalar_coeff.
// A result passes the stage 1 read, operand, product and sum registers in turn.
// One request per cycle while the output is not stalled; in the last column
// each request stalls intake while the single output port emits both results.
// Line stores are RAMs of MAX_GRID rows, one read and one write per cycle.
// Reset clears counters, valid bits and config registers (grid 256, scalar mode).
// A stall on m_ready backs the four-stage pipeline up stage by stage;
// s_ready drops only when every stage holds a request.
`include "adi_rhs_column_stencil_assert.svh"

module adi_rhs_column_stencil #(
    parameter int MAX_GRID = 256
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // configuration
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [adi_rcs_pkg::CFG_ADDR_WIDTH-1:0]      cfg_index,
    input  logic [adi_rcs_pkg::VALUE_WIDTH-1:0]         cfg_data,
    // grid points
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0]  s_u_value,
    input  logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0]  s_diag_coeff,
    input  logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0]  s_source_term,
    input  logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0]  s_sub_coeff,
    input  logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0]  s_hyp_coeff,
    // results
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [adi_rcs_pkg::VALUE_WIDTH-1:0]  m_rhs_value,
    output logic [adi_rcs_pkg::INDEX_WIDTH-1:0]         m_row_index,
    output logic [adi_rcs_pkg::INDEX_WIDTH-1:0]         m_col_index,
    output logic                                        m_last_in_step,
    output logic                                        m_end_of_grid
);

    localparam int VW  = adi_rcs_pkg::VALUE_WIDTH;
    localparam int IW  = adi_rcs_pkg::INDEX_WIDTH;
    localparam int GW  = adi_rcs_pkg::GRID_WIDTH;
    localparam int CW  = $clog2(MAX_GRID);
    localparam int NW  = $clog2(MAX_GRID + 1);
    localparam int SZW = (NW > GW) ? NW : GW;

    // configuration registers
    logic [GW-1:0]        grid_size_reg;
    logic                 coeff_mode_reg;
    logic signed [VW-1:0] scalar_coeff_reg;
    logic                 grid_wr;

    // grid position counters
    logic [CW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [SZW-1:0] size_ext;
    logic [NW-1:0]  n_eff;
    logic [NW-1:0]  n_m1;
    logic           row_last;
    logic           col_last;
    logic           accept;

    // line store RAMs
    logic signed [VW-1:0] u_even_mem [MAX_GRID];
    logic signed [VW-1:0] u_odd_mem  [MAX_GRID];
    logic signed [VW-1:0] diag_mem   [MAX_GRID];
    logic signed [VW-1:0] src_mem    [MAX_GRID];
    logic signed [VW-1:0] sub_mem    [MAX_GRID];
    logic signed [VW-1:0] hyp_mem    [MAX_GRID];

    // stage 1: request plus line store read data
    logic                 v1_reg;
    logic signed [VW-1:0] u1_reg, d1_reg, f1_reg, sa1_reg, sc1_reg;
    logic signed [VW-1:0] ue_rd_reg, uo_rd_reg, dp_rd_reg, fp_rd_reg, ap_rd_reg, cp_rd_reg;
    logic                 par1_reg, first1_reg, p0_1_reg, clast1_reg, rlast1_reg;
    logic [CW-1:0]        row1_reg, col1_reg;

    // stage 2: operand selection
    logic                 v2_reg;
    adi_rcs_pkg::ops_t    ops_a_reg, ops_b_reg;
    adi_rcs_pkg::ops_t    ops_a_next, ops_b_next;
    adi_rcs_pkg::meta_t   meta2_reg, meta2_next;
    logic signed [VW-1:0] u_up, u_up2;
    logic [CW+IW-1:0]     row_ext, colp_ext, colc_ext;

    // stages 3 and 4
    logic                 v3_reg;
    adi_rcs_pkg::meta_t   meta3_reg, meta4_reg;
    logic                 out_valid_reg;
    logic                 sel_reg;
    logic                 en2, en3, en4;
    adi_rcs_pkg::stage_en_t stage_en;
    logic signed [VW-1:0] rhs_a, rhs_b;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign grid_wr   = cfg_valid && (cfg_index == adi_rcs_pkg::CFG_GRID_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg    <= adi_rcs_pkg::GRID_SIZE_RESET;
            coeff_mode_reg   <= 1'b0;
            scalar_coeff_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                adi_rcs_pkg::CFG_GRID_SIZE:    grid_size_reg    <= cfg_data[GW-1:0];
                adi_rcs_pkg::CFG_COEFF_MODE:   coeff_mode_reg   <= cfg_data[0];
                adi_rcs_pkg::CFG_SCALAR_COEFF: scalar_coeff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective grid size, clamped to 2..MAX_GRID
    always_comb begin
        size_ext = SZW'(grid_size_reg);
        if (size_ext < SZW'(2)) begin
            n_eff = NW'(2);
        end else if (size_ext > SZW'(MAX_GRID)) begin
            n_eff = NW'(MAX_GRID);
        end else begin
            n_eff = size_ext[NW-1:0];
        end
        n_m1     = n_eff - NW'(1);
        row_last = (NW'(row_reg) == n_m1);
        col_last = (NW'(col_reg) == n_m1);
    end

    // ---------------- pipeline control ----------------
    assign en4     = !out_valid_reg || (m_ready && (!meta4_reg.two || sel_reg));
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign s_ready = !v1_reg || en2;
    assign accept  = s_valid && s_ready;

    assign stage_en.prod = en3;
    assign stage_en.sum  = en4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                out_valid_reg <= v3_reg && meta3_reg.has_res;
                sel_reg       <= 1'b0;
            end else if (m_ready) begin
                sel_reg <= 1'b1;
            end
        end
    end

    // grid position; a grid_size write restarts the grid
    always_ff @(posedge aclk) begin
        if (!aresetn || grid_wr) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (row_last) begin
                row_reg <= '0;
                col_reg <= col_last ? '0 : col_reg + CW'(1);
            end else begin
                row_reg <= row_reg + CW'(1);
            end
        end
    end

    // ---------------- stage 1: line stores, read before write ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            ue_rd_reg <= u_even_mem[row_reg];
            uo_rd_reg <= u_odd_mem[row_reg];
            dp_rd_reg <= diag_mem[row_reg];
            fp_rd_reg <= src_mem[row_reg];
            ap_rd_reg <= sub_mem[row_reg];
            cp_rd_reg <= hyp_mem[row_reg];
            if (!col_reg[0]) begin
                u_even_mem[row_reg] <= s_u_value;
            end else begin
                u_odd_mem[row_reg] <= s_u_value;
            end
            diag_mem[row_reg] <= s_diag_coeff;
            src_mem[row_reg]  <= s_source_term;
            sub_mem[row_reg]  <= s_sub_coeff;
            hyp_mem[row_reg]  <= s_hyp_coeff;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            u1_reg     <= s_u_value;
            d1_reg     <= s_diag_coeff;
            f1_reg     <= s_source_term;
            sa1_reg    <= s_sub_coeff;
            sc1_reg    <= s_hyp_coeff;
            par1_reg   <= col_reg[0];
            first1_reg <= (col_reg == '0);
            p0_1_reg   <= (col_reg == CW'(1));
            clast1_reg <= col_last;
            rlast1_reg <= row_last;
            row1_reg   <= row_reg;
            col1_reg   <= col_reg;
        end
    end

    // ---------------- stage 2: operand selection ----------------
    always_comb begin
        // previous column sits in the other parity bank, two back in the same one
        u_up  = par1_reg ? ue_rd_reg : uo_rd_reg;
        u_up2 = par1_reg ? uo_rd_reg : ue_rd_reg;

        // result for the previous column; column 0 mirrors its right neighbor
        ops_a_next.a  = coeff_mode_reg ? ap_rd_reg : scalar_coeff_reg;
        ops_a_next.ul = p0_1_reg ? u1_reg : u_up2;
        ops_a_next.c  = coeff_mode_reg ? cp_rd_reg : scalar_coeff_reg;
        ops_a_next.ur = u1_reg;
        ops_a_next.d  = dp_rd_reg;
        ops_a_next.u  = u_up;
        ops_a_next.f  = fp_rd_reg;

        // result for the last column itself; right neighbor mirrors the left
        ops_b_next.a  = coeff_mode_reg ? sa1_reg : scalar_coeff_reg;
        ops_b_next.ul = u_up;
        ops_b_next.c  = coeff_mode_reg ? sc1_reg : scalar_coeff_reg;
        ops_b_next.ur = u_up;
        ops_b_next.d  = d1_reg;
        ops_b_next.u  = u1_reg;
        ops_b_next.f  = f1_reg;

        row_ext  = {{IW{1'b0}}, row1_reg};
        colp_ext = {{IW{1'b0}}, col1_reg - CW'(1)};
        colc_ext = {{IW{1'b0}}, col1_reg};

        meta2_next.row      = row_ext[IW-1:0];
        meta2_next.col_prev = colp_ext[IW-1:0];
        meta2_next.col_cur  = colc_ext[IW-1:0];
        meta2_next.has_res  = !first1_reg;
        meta2_next.two      = clast1_reg;
        meta2_next.end_grid = clast1_reg && rlast1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            ops_a_reg <= ops_a_next;
            ops_b_reg <= ops_b_next;
            meta2_reg <= meta2_next;
        end
    end

    // ---------------- stages 3 and 4: arithmetic ----------------
    adi_rcs_stencil_unit u_unit_prev (
        .aclk (aclk),
        .en   (stage_en),
        .ops  (ops_a_reg),
        .rhs  (rhs_a)
    );

    adi_rcs_stencil_unit u_unit_last (
        .aclk (aclk),
        .en   (stage_en),
        .ops  (ops_b_reg),
        .rhs  (rhs_b)
    );

    always_ff @(posedge aclk) begin
        if (en3) begin
            meta3_reg <= meta2_reg;
        end
        if (en4) begin
            meta4_reg <= meta3_reg;
        end
    end

    // ---------------- output ----------------
    assign m_valid        = out_valid_reg;
    assign m_rhs_value    = sel_reg ? rhs_b : rhs_a;
    assign m_row_index    = meta4_reg.row;
    assign m_col_index    = sel_reg ? meta4_reg.col_cur : meta4_reg.col_prev;
    assign m_last_in_step = sel_reg || !meta4_reg.two;
    assign m_end_of_grid  = sel_reg && meta4_reg.end_grid;

    // ---------------- assertions ----------------
    `ADI_RCS_ASSERT_NOW(a_sel_pair, sel_reg, out_valid_reg && meta4_reg.two,
        "second result selected without a pending pair")
    `ADI_RCS_ASSERT_NEXT(a_pair_follows,
        m_valid && m_ready && meta4_reg.two && !sel_reg, m_valid && sel_reg,
        "second result of a pair did not follow the first")
    `ADI_RCS_ASSERT_NOW(a_full_backpressure,
        v1_reg && v2_reg && v3_reg && out_valid_reg && !m_ready, !s_ready,
        "request taken while the pipeline is full and stalled")
    `ADI_RCS_ASSERT_NOW(a_pos_bound, 1'b1,
        (NW'(row_reg) < n_eff) && (NW'(col_reg) < n_eff),
        "grid position outside the grid")

endmodule
